/* src/uhqp_pkg.sv */
// Package for the universal hash quadratic-probe insert block.
// Holds shared constants, state codes, status codes and control structs.
// No dependencies.
`timescale 1ns / 1ps
package uhqp_pkg;

  localparam int unsigned TableSize = 1024;
  localparam int unsigned KeyW = 31;
  localparam int unsigned CoefW = 24;
  localparam int unsigned ProdW = 56;
  localparam int unsigned SlotW = 10;
  localparam int unsigned InsW = 11;
  localparam int unsigned ColW = 32;
  localparam int unsigned PrbW = 40;
  localparam logic [CoefW-1:0] MultReset = 24'd1;
  localparam logic [CoefW-1:0] AddReset = 24'd0;
  localparam logic [CoefW-1:0] PrimeReset = 24'd10000019;

  localparam logic [1:0] StInserted = 2'd0;
  localparam logic [1:0] StDup = 2'd1;
  localparam logic [1:0] StFull = 2'd2;

  localparam logic [1:0] RegMult = 2'd0;
  localparam logic [1:0] RegAdd = 2'd1;
  localparam logic [1:0] RegPrime = 2'd2;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_MUL,
    S_MOD,
    S_HOME,
    S_RD,
    S_CHK,
    S_DONE
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic clr;       // clear one table entry
    logic load;      // latch key, start product
    logic mod_step;  // one restoring-division bit
    logic set_home;  // slot <= home
    logic rd;        // read memory at slot
    logic adv;       // next probe slot
    logic wr;        // store key at slot
    logic fin;       // emit result
    logic [1:0] status;
    logic cnt_tot;   // count collision and probes
    logic set_full;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_done;  // last entry being cleared
    logic mod_done;
    logic valid;     // slot occupied
    logic match;     // stored key equals key
    logic limit;     // probes exhausted
    logic full;
  } sts_t;

endpackage

/* src/uhqp_ctrl.sv */
// Controller state machine for the hash insert block.
// Depends on uhqp_pkg.
`timescale 1ns / 1ps
module uhqp_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  uhqp_pkg::sts_t  sts_i,
  output uhqp_pkg::ctl_t  ctl_o
);

  uhqp_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= uhqp_pkg::S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      uhqp_pkg::S_CLR: begin
        if (sts_i.clr_done) begin
          state_d = uhqp_pkg::S_IDLE;
        end
      end
      uhqp_pkg::S_IDLE: begin
        if (start_i) begin
          state_d = sts_i.full ? uhqp_pkg::S_DONE : uhqp_pkg::S_MUL;
        end
      end
      uhqp_pkg::S_MUL: state_d = uhqp_pkg::S_MOD;
      uhqp_pkg::S_MOD: begin
        if (sts_i.mod_done) begin
          state_d = uhqp_pkg::S_HOME;
        end
      end
      uhqp_pkg::S_HOME: state_d = uhqp_pkg::S_RD;
      uhqp_pkg::S_RD: state_d = uhqp_pkg::S_CHK;
      uhqp_pkg::S_CHK: begin
        if (!sts_i.valid || sts_i.match || sts_i.limit) begin
          state_d = uhqp_pkg::S_IDLE;
        end else begin
          state_d = uhqp_pkg::S_RD;
        end
      end
      uhqp_pkg::S_DONE: state_d = uhqp_pkg::S_IDLE;
      default: state_d = uhqp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl_o = '0;
    busy_o = (state_q != uhqp_pkg::S_IDLE);
    unique case (state_q)
      uhqp_pkg::S_CLR: ctl_o.clr = 1'b1;
      uhqp_pkg::S_IDLE: ctl_o.load = start_i && !sts_i.full;
      uhqp_pkg::S_MOD: ctl_o.mod_step = 1'b1;
      uhqp_pkg::S_HOME: ctl_o.set_home = 1'b1;
      uhqp_pkg::S_RD: ctl_o.rd = 1'b1;
      uhqp_pkg::S_CHK: begin
        if (sts_i.limit) begin
          ctl_o.fin = 1'b1;
          ctl_o.status = uhqp_pkg::StFull;
          ctl_o.cnt_tot = 1'b1;
          ctl_o.set_full = 1'b1;
        end else if (sts_i.valid && sts_i.match) begin
          ctl_o.fin = 1'b1;
          ctl_o.status = uhqp_pkg::StDup;
        end else if (!sts_i.valid) begin
          ctl_o.fin = 1'b1;
          ctl_o.wr = 1'b1;
          ctl_o.status = uhqp_pkg::StInserted;
          ctl_o.cnt_tot = 1'b1;
        end else begin
          ctl_o.adv = 1'b1;
        end
      end
      uhqp_pkg::S_DONE: begin
        ctl_o.fin = 1'b1;
        ctl_o.status = uhqp_pkg::StFull;
      end
      default: ctl_o = '0;
    endcase
  end

endmodule

/* src/uhqp_dpath.sv */
// Datapath: hash product, bit-serial modulo, probe walk over key memory, totals.
// Depends on uhqp_pkg.
`timescale 1ns / 1ps
module uhqp_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [uhqp_pkg::KeyW-1:0]     key_i,
  input  logic [uhqp_pkg::CoefW-1:0]    mult_i,
  input  logic [uhqp_pkg::CoefW-1:0]    add_i,
  input  logic [uhqp_pkg::CoefW-1:0]    prime_i,
  input  uhqp_pkg::ctl_t                ctl_i,
  output uhqp_pkg::sts_t                sts_o,
  output logic                          done_o,
  output logic [1:0]                    status_o,
  output logic [uhqp_pkg::SlotW-1:0]    slot_o,
  output logic                          collided_o,
  output logic [uhqp_pkg::SlotW-1:0]    probes_used_o,
  output logic [uhqp_pkg::InsW-1:0]     inserted_total_o,
  output logic [uhqp_pkg::ColW-1:0]     collision_total_o,
  output logic [uhqp_pkg::PrbW-1:0]     probe_total_o
);

  localparam int unsigned AW = $clog2(uhqp_pkg::TableSize);
  localparam int unsigned CW = $clog2(uhqp_pkg::TableSize / 2 + 1);
  localparam int unsigned PW = uhqp_pkg::ProdW + 1;
  localparam int unsigned BW = $clog2(PW + 1);
  localparam int unsigned PCW = (AW > 2 * CW) ? AW : 2 * CW;
  localparam logic [CW-1:0] Limit = CW'(uhqp_pkg::TableSize / 2);
  localparam logic [AW-1:0] ClrLast = AW'(uhqp_pkg::TableSize - 1);

  logic [uhqp_pkg::KeyW-1:0] key_q;
  logic [PW-1:0]             sum_q;
  logic [uhqp_pkg::CoefW:0]  rem_q;
  logic [BW-1:0]             bit_q;
  logic                      mul_pend_q;
  logic                      mod_done;
  logic [AW-1:0]             slot_q;
  logic [CW-1:0]             used_q;
  logic                      coll_q;
  logic                      first_q;
  logic [uhqp_pkg::KeyW:0]   mem_q [uhqp_pkg::TableSize];  // {occupied, key}
  logic [uhqp_pkg::KeyW:0]   rdata_q;
  logic                      rvalid;
  logic [AW-1:0]             clr_q;
  logic                      full_q;
  logic [uhqp_pkg::InsW-1:0] ins_q;
  logic [uhqp_pkg::ColW-1:0] col_q;
  logic [uhqp_pkg::PrbW-1:0] prb_q;
  logic [uhqp_pkg::CoefW:0]  rem_sh;
  logic [uhqp_pkg::CoefW+1:0] rem_try;
  logic [PCW-1:0]            sq;
  logic [uhqp_pkg::PrbW:0]   prb_sum;
  logic [AW-1:0]             home;
  logic                      coll_now;

  assign rem_sh  = {rem_q[uhqp_pkg::CoefW-1:0], sum_q[PW-1]};
  assign rem_try = {1'b0, rem_sh} - {2'b00, prime_i};
  assign sq = PCW'(used_q + 1'b1) * PCW'(used_q + 1'b1);
  assign home = (prime_i == '0) ? sum_q[AW-1:0] : rem_q[AW-1:0];
  assign prb_sum = {1'b0, prb_q} + (uhqp_pkg::PrbW+1)'(used_q);
  assign mod_done = (prime_i == '0) || (bit_q == BW'(PW));
  assign rvalid = rdata_q[uhqp_pkg::KeyW];
  assign coll_now = coll_q || (first_q && rvalid);

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      key_q <= key_i;
      sum_q <= '0;
      rem_q <= '0;
      bit_q <= '0;
    end else if (mul_pend_q) begin
      sum_q <= PW'(mult_i) * PW'(key_q) + PW'(add_i);
    end else if (ctl_i.mod_step && !mod_done) begin
      if (prime_i != '0) begin
        rem_q <= rem_try[uhqp_pkg::CoefW+1] ? rem_sh : rem_try[uhqp_pkg::CoefW:0];
        sum_q <= {sum_q[PW-2:0], sum_q[PW-1]};
      end
      bit_q <= bit_q + 1'b1;
    end
    if (ctl_i.set_home) begin
      slot_q <= home;
      used_q <= '0;
    end else if (ctl_i.adv) begin
      slot_q <= AW'(slot_q + AW'(sq));
      used_q <= used_q + 1'b1;
    end
    if (ctl_i.rd) begin
      rdata_q <= mem_q[slot_q];
    end
    if (ctl_i.clr) begin
      mem_q[clr_q] <= '0;
    end else if (ctl_i.wr) begin
      mem_q[slot_q] <= {1'b1, key_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_pend_q <= 1'b0;
      first_q <= 1'b0;
      coll_q <= 1'b0;
      full_q <= 1'b0;
      ins_q <= '0;
      col_q <= '0;
      prb_q <= '0;
      clr_q <= '0;
      done_o <= 1'b0;
    end else begin
      mul_pend_q <= ctl_i.load;
      done_o <= ctl_i.fin;
      if (ctl_i.clr) begin
        clr_q <= clr_q + 1'b1;
      end
      if (ctl_i.set_home) begin
        first_q <= 1'b1;
        coll_q <= 1'b0;
      end
      if (ctl_i.adv) begin
        first_q <= 1'b0;
      end
      if ((ctl_i.adv || ctl_i.fin) && first_q && rvalid) begin
        coll_q <= 1'b1;
      end
      if (ctl_i.wr) begin
        if (ins_q != '1) begin
          ins_q <= ins_q + 1'b1;
        end
      end
      if (ctl_i.cnt_tot && coll_now) begin
        if (col_q != '1) begin
          col_q <= col_q + 1'b1;
        end
        prb_q <= prb_sum[uhqp_pkg::PrbW] ? '1 : prb_sum[uhqp_pkg::PrbW-1:0];
      end
      if (ctl_i.set_full) begin
        full_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.fin) begin
      status_o <= ctl_i.status;
      slot_o <= full_q ? '0 : uhqp_pkg::SlotW'(slot_q);
      collided_o <= full_q ? 1'b0 : coll_now;
      probes_used_o <= full_q ? '0 : uhqp_pkg::SlotW'(used_q);
    end
  end

  assign inserted_total_o = ins_q;
  assign collision_total_o = col_q;
  assign probe_total_o = prb_q;

  assign sts_o.clr_done = (clr_q == ClrLast);
  assign sts_o.mod_done = mod_done;
  assign sts_o.valid = rvalid;
  assign sts_o.match = (rdata_q[uhqp_pkg::KeyW-1:0] == key_q);
  assign sts_o.limit = (used_q == Limit);
  assign sts_o.full = full_q;

endmodule

/* src/universal_hash_quadratic_probe_insert.sv */
// Top level of the universal hash quadratic-probe insert block.
// Depends on uhqp_pkg, uhqp_ctrl, uhqp_dpath.
//
// channel | signals                           | handshake
// input   | key_i                             | start_i & !busy_o
// result  | status_o slot_o ... probe_total_o | done_o, one cycle
// config  | psel penable pwrite paddr pwdata  | APB, pready high
//
// For each key the product is formed, then a 57-step restoring modulo reduces it,
// then each probed slot takes one memory read and one check.
// With a zero modulus the modulo is skipped; when the table is full, the key is
// answered with status full and no hash is formed.
// The next key can be taken at the edge that takes the result.
// After reset busy_o stays high while the table is cleared.
// Results cannot be held off.
`timescale 1ns / 1ps
module universal_hash_quadratic_probe_insert (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [uhqp_pkg::KeyW-1:0]     key_i,
  output logic                          done_o,
  output logic [1:0]                    status_o,
  output logic [uhqp_pkg::SlotW-1:0]    slot_o,
  output logic                          collided_o,
  output logic [uhqp_pkg::SlotW-1:0]    probes_used_o,
  output logic [uhqp_pkg::InsW-1:0]     inserted_total_o,
  output logic [uhqp_pkg::ColW-1:0]     collision_total_o,
  output logic [uhqp_pkg::PrbW-1:0]     probe_total_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic [uhqp_pkg::CoefW-1:0] mult_q, add_q, prime_q;
  uhqp_pkg::ctl_t ctl;
  uhqp_pkg::sts_t sts;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mult_q <= uhqp_pkg::MultReset;
      add_q <= uhqp_pkg::AddReset;
      prime_q <= uhqp_pkg::PrimeReset;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        uhqp_pkg::RegMult: mult_q <= pwdata[uhqp_pkg::CoefW-1:0];
        uhqp_pkg::RegAdd: add_q <= pwdata[uhqp_pkg::CoefW-1:0];
        uhqp_pkg::RegPrime: prime_q <= pwdata[uhqp_pkg::CoefW-1:0];
        default: mult_q <= mult_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      uhqp_pkg::RegMult: prdata = {8'd0, mult_q};
      uhqp_pkg::RegAdd: prdata = {8'd0, add_q};
      uhqp_pkg::RegPrime: prdata = {8'd0, prime_q};
      default: prdata = '0;
    endcase
  end

  uhqp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .sts_i  (sts),
    .ctl_o  (ctl)
  );

  uhqp_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .key_i            (key_i),
    .mult_i           (mult_q),
    .add_i            (add_q),
    .prime_i          (prime_q),
    .ctl_i            (ctl),
    .sts_o            (sts),
    .done_o           (done_o),
    .status_o         (status_o),
    .slot_o           (slot_o),
    .collided_o       (collided_o),
    .probes_used_o    (probes_used_o),
    .inserted_total_o (inserted_total_o),
    .collision_total_o(collision_total_o),
    .probe_total_o    (probe_total_o)
  );

endmodule

/* src/uhqp_checker.sv */
// Port-level checker for the hash insert block, bound to the top level.
// Depends on uhqp_pkg and universal_hash_quadratic_probe_insert.
`timescale 1ns / 1ps
module uhqp_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start_i,
  input logic                       busy_o,
  input logic                       done_o,
  input logic [1:0]                 status_o,
  input logic [uhqp_pkg::InsW-1:0]  inserted_total_o,
  input logic [uhqp_pkg::ColW-1:0]  collision_total_o
);

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("accept did not raise busy");

  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> status_o != 2'd3) else $error("bad status");

  a_ins_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inserted_total_o >= $past(inserted_total_o)) else $error("insert total fell");

  a_col_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    collision_total_o >= $past(collision_total_o)) else $error("collision total fell");

endmodule

bind universal_hash_quadratic_probe_insert uhqp_checker u_uhqp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start_i          (start_i),
  .busy_o           (busy_o),
  .done_o           (done_o),
  .status_o         (status_o),
  .inserted_total_o (inserted_total_o),
  .collision_total_o(collision_total_o)
);

/* tb/universal_hash_quadratic_probe_insert_tb.sv */
// Testbench for universal_hash_quadratic_probe_insert: drives keys and APB register writes,
// predicts each result word from its own copy of the hash table and totals, checks every field.
// Depends on uhqp_pkg and the block under test.
`timescale 1ns / 1ps
module universal_hash_quadratic_probe_insert_tb;

  localparam int unsigned Slots = uhqp_pkg::TableSize;
  localparam logic [1:0] RegUnused = 2'd3;

  typedef struct packed {
    logic [1:0]                    status;
    logic [uhqp_pkg::SlotW-1:0]    slot;
    logic                          collided;
    logic [uhqp_pkg::SlotW-1:0]    probes;
    logic [uhqp_pkg::InsW-1:0]     ins_total;
    logic [uhqp_pkg::ColW-1:0]     col_total;
    logic [uhqp_pkg::PrbW-1:0]     prb_total;
  } hash_word_t;

  class insert_scoreboard;
    logic [uhqp_pkg::KeyW-1:0]  stored_key[Slots];
    bit                         occupied[Slots];
    bit                         full;
    logic [uhqp_pkg::InsW-1:0]  ins_cnt;
    logic [uhqp_pkg::ColW-1:0]  col_cnt;
    logic [uhqp_pkg::PrbW-1:0]  prb_cnt;
    logic [uhqp_pkg::CoefW-1:0] mult, add, prime;
    hash_word_t                 pending_q[$];
    int                         errors;

    function new();
      foreach (occupied[i]) occupied[i] = 1'b0;
      full = 1'b0; ins_cnt = '0; col_cnt = '0; prb_cnt = '0; errors = 0;
      mult = uhqp_pkg::MultReset; add = uhqp_pkg::AddReset; prime = uhqp_pkg::PrimeReset;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      if (idx == uhqp_pkg::RegMult) mult = val[uhqp_pkg::CoefW-1:0];
      else if (idx == uhqp_pkg::RegAdd) add = val[uhqp_pkg::CoefW-1:0];
      else if (idx == uhqp_pkg::RegPrime) prime = val[uhqp_pkg::CoefW-1:0];
    endfunction

    function void store(int unsigned s, logic [uhqp_pkg::KeyW-1:0] key);
      stored_key[s] = key;
      occupied[s] = 1'b1;
      if (ins_cnt != '1) ins_cnt++;
    endfunction

    function void note_key(logic [uhqp_pkg::KeyW-1:0] key);
      hash_word_t w;
      longint unsigned h, step;
      int unsigned s, used;
      bit found;
      w = '0;
      if (full) begin
        w.status = uhqp_pkg::StFull;
      end else begin
        h = longint'(mult) * longint'(key) + longint'(add);
        if (prime != 0) h = h % longint'(prime);
        s = 32'(h % Slots);
        used = 0;
        found = 1'b0;
        w.status = uhqp_pkg::StInserted;
        if (!occupied[s]) begin
          store(s, key);
        end else begin
          w.collided = 1'b1;
          step = 1;
          while (occupied[s] && !found && used < Slots / 2) begin
            if (stored_key[s] == key) begin
              found = 1'b1;
            end else begin
              s = 32'((s + step * step) % Slots);
              used++;
              step++;
            end
          end
          if (found) begin
            w.status = uhqp_pkg::StDup;
          end else begin
            if (col_cnt != '1) col_cnt++;
            if ({1'b0, prb_cnt} + used > {1'b0, {uhqp_pkg::PrbW{1'b1}}}) prb_cnt = '1;
            else prb_cnt = prb_cnt + used;
            if (used >= Slots / 2) begin
              w.status = uhqp_pkg::StFull;
              full = 1'b1;
            end else begin
              store(s, key);
            end
          end
        end
        w.slot = s[uhqp_pkg::SlotW-1:0];
        w.probes = used[uhqp_pkg::SlotW-1:0];
      end
      w.ins_total = ins_cnt;
      w.col_total = col_cnt;
      w.prb_total = prb_cnt;
      pending_q.push_back(w);
    endfunction

    function void check(hash_word_t got);
      hash_word_t exp_w;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, got);
        errors++;
        return;
      end
      exp_w = pending_q.pop_front();
      if (got.status !== exp_w.status)
        $display("%0t: status exp %0d got %0d", $time, exp_w.status, got.status);
      if (got.slot !== exp_w.slot)
        $display("%0t: slot exp %0d got %0d", $time, exp_w.slot, got.slot);
      if (got.collided !== exp_w.collided)
        $display("%0t: collided exp %0d got %0d", $time, exp_w.collided, got.collided);
      if (got.probes !== exp_w.probes)
        $display("%0t: probes_used exp %0d got %0d", $time, exp_w.probes, got.probes);
      if (got.ins_total !== exp_w.ins_total)
        $display("%0t: inserted_total exp %0d got %0d", $time, exp_w.ins_total,
                 got.ins_total);
      if (got.col_total !== exp_w.col_total)
        $display("%0t: collision_total exp %0d got %0d", $time, exp_w.col_total,
                 got.col_total);
      if (got.prb_total !== exp_w.prb_total)
        $display("%0t: probe_total exp %0d got %0d", $time, exp_w.prb_total,
                 got.prb_total);
      if (got !== exp_w) errors++;
    endfunction
  endclass

  logic clk_i, rst_ni, start_i, busy_o, done_o, collided_o;
  logic [uhqp_pkg::KeyW-1:0] key_i;
  logic [1:0] status_o;
  logic [uhqp_pkg::SlotW-1:0] slot_o, probes_used_o;
  logic [uhqp_pkg::InsW-1:0] inserted_total_o;
  logic [uhqp_pkg::ColW-1:0] collision_total_o;
  logic [uhqp_pkg::PrbW-1:0] probe_total_o;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;

  insert_scoreboard sb;
  logic [uhqp_pkg::KeyW-1:0] sent_keys[$];
  bit quiet_stretch;

  universal_hash_quadratic_probe_insert uut (.*);

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk_i)
    if (rst_ni && done_o)
      sb.check({status_o, slot_o, collided_o, probes_used_o, inserted_total_o,
                collision_total_o, probe_total_o});

  task automatic drain();
    start_i <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    drain();
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    sb.set_reg(idx, val);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk_i);
  endtask

  task automatic send_key(logic [uhqp_pkg::KeyW-1:0] key);
    if (!quiet_stretch && $urandom_range(99) < 22) begin
      start_i <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    start_i <= 1;
    key_i <= key;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.note_key(key);
    sent_keys.push_back(key);
  endtask

  function automatic logic [uhqp_pkg::KeyW-1:0] pick_key();
    int unsigned r;
    logic [31:0] v;
    r = $urandom_range(99);
    if (r < 55 && sent_keys.size() > 0) return sent_keys[$urandom_range(sent_keys.size() - 1)];
    if (r < 65) begin
      v = $urandom_range(4095);
      return v[uhqp_pkg::KeyW-1:0];
    end
    if (r < 68) return 31'h7FFF_FFFE;
    v = $urandom_range(32'h7FFF_FFFE);
    return v[uhqp_pkg::KeyW-1:0];
  endfunction

  task automatic random_config();
    case ($urandom_range(3))
      0: write_reg(uhqp_pkg::RegMult, 32'hFF_FFFF);
      1: write_reg(uhqp_pkg::RegMult, 32'd1);
      default: write_reg(uhqp_pkg::RegMult, $urandom_range(1, 32'hFF_FFFF));
    endcase
    write_reg(uhqp_pkg::RegAdd,
              ($urandom_range(3) == 0) ? 32'hFF_FFFF : $urandom_range(32'hFF_FFFF));
    case ($urandom_range(4))
      0: write_reg(uhqp_pkg::RegPrime, 32'd0);
      1: write_reg(uhqp_pkg::RegPrime, 32'd2);
      2: write_reg(uhqp_pkg::RegPrime, 32'hFF_FFFF);
      3: write_reg(uhqp_pkg::RegPrime, {8'd0, uhqp_pkg::PrimeReset});
      default: write_reg(uhqp_pkg::RegPrime, $urandom_range(1000, 32'hFF_FFFF));
    endcase
  endtask

  initial begin
    int unsigned extra;
    logic [31:0] rnd;
    sb = new();
    rst_ni = 0; start_i = 0; key_i = '0; quiet_stretch = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    repeat (3) @(posedge clk_i);

    // directed: reset hash, collisions, duplicates, extremes
    send_key(31'd0);
    send_key(31'h7FFF_FFFE);
    send_key(31'd0);
    send_key(31'd1024);
    send_key(31'd2048);
    send_key(31'd2048);
    send_key(31'h5555_5555);
    send_key(31'h2AAA_AAAA);
    write_reg(uhqp_pkg::RegMult, 32'd0);
    write_reg(uhqp_pkg::RegAdd, 32'hFF_FFFF);
    send_key(31'd7);
    send_key(31'd9);
    send_key(31'd7);
    write_reg(uhqp_pkg::RegMult, 32'hFF_FFFF);
    write_reg(uhqp_pkg::RegPrime, 32'd0);
    send_key(31'h7FFF_FFFE);
    send_key(31'd12345);
    send_key(31'h7FFF_FFFE);
    write_reg(uhqp_pkg::RegPrime, 32'd2);
    write_reg(uhqp_pkg::RegAdd, 32'd0);
    send_key(31'd3);
    send_key(31'd4);
    write_reg(RegUnused, 32'hFFFF_FFFF);
    write_reg(uhqp_pkg::RegPrime, 32'hFFFF_FFFF);
    send_key(31'd99);
    send_key(31'd100);

    for (int ph = 0; ph < 6; ph++) begin
      random_config();
      for (int n = 0; n < 325; n++) begin
        quiet_stretch = (ph == 2 && n >= 50 && n < 250);
        if (ph == 1 && n == 150) drain();
        send_key(pick_key());
      end
    end
    quiet_stretch = 0;

    // fresh keys until the table gives up (at most 100), then ten more picked keys
    extra = 0;
    while (!sb.full && extra < 100) begin
      rnd = $urandom_range(32'h7FFF_FFFE);
      send_key(rnd[uhqp_pkg::KeyW-1:0]);
      extra++;
    end
    for (int n = 0; n < 10; n++) send_key(pick_key());
    start_i <= 0;

    extra = 0;
    while (sb.pending_q.size() != 0 && extra < 200_000) begin
      @(posedge clk_i);
      extra++;
    end
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
